>>> sv/homography_object_steering_defines.svh
// ----------------------------------------------------------------------------
// Homography object steering assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_OBJECT_STEERING_DEFINES_SVH
`define HOMOGRAPHY_OBJECT_STEERING_DEFINES_SVH

// Same-cycle implication.
`define HOS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HOS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hos_pkg.sv
// ----------------------------------------------------------------------------
// Homography object steering package
// Payload types, register map, fixed-point widths and divider interface.
// ----------------------------------------------------------------------------
package hos_pkg;

  localparam int KIND_W   = 8;
  localparam int DIM_W    = 12;
  localparam int HOM_W    = 32;
  localparam int TURN_W   = 16;
  localparam int CENTER_W = 12;
  localparam int RATE_W   = 15;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_MAX    = 2'd1;
  localparam logic [1:0] REG_MIN    = 2'd2;

  localparam logic [CENTER_W-1:0] CENTER_RST = 12'd320;
  localparam logic [RATE_W-1:0]   MAX_RST    = 15'd2458;
  localparam logic [RATE_W-1:0]   MIN_RST    = 15'd1638;

  localparam logic [KIND_W-1:0] KIND_FOLLOW = 8'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 8'd2;

  // Datapath widths, sized from the worst-case magnitudes of the Q16.16 maths.
  localparam int PRD_W     = 44;
  localparam int NUM_W     = 46;
  localparam int HOM_FRAC  = 16;
  localparam int DVS_W     = 45;
  localparam int QUO_W     = DVS_W + HOM_FRAC;
  localparam int ACC_W     = 64;
  localparam int FRAC_SH   = 18;
  localparam int X_W       = ACC_W - FRAC_SH;
  localparam int DIFF_W    = X_W + 1;
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int TPROD_W   = QUO_W + 1;
  localparam int RND_BIAS  = 2 ** FRAC_SH - 1;

  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam int SAT_POS     = 32767;
  localparam int SAT_NEG_MAG = 32768;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

  typedef struct packed {
    logic [KIND_W-1:0]        object_kind;
    logic [DIM_W-1:0]         obj_width;
    logic [DIM_W-1:0]         obj_height;
    logic signed [HOM_W-1:0]  hom_r0c0;
    logic signed [HOM_W-1:0]  hom_r0c1;
    logic signed [HOM_W-1:0]  hom_r0c2;
    logic signed [HOM_W-1:0]  hom_r2c0;
    logic signed [HOM_W-1:0]  hom_r2c1;
    logic signed [HOM_W-1:0]  hom_r2c2;
  } hos_in_t;

  typedef struct packed {
    logic                     forward_speed;
    logic signed [TURN_W-1:0] turn_rate;
    logic                     stop_active;
  } hos_out_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/hos_div.sv
// ----------------------------------------------------------------------------
// Homography object steering divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "homography_object_steering_defines.svh"

module hos_div
  import hos_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [QUO_W-1:0]     quo_q;

  logic [DVS_W:0]       part_w;
  logic [DVS_W:0]       trial_w;
  logic                 ge_w;

  always_comb begin
    part_w  = {rem_q, quo_q[QUO_W-1]};
    trial_w = part_w - {1'b0, dvs_q};
    ge_w    = !trial_w[DVS_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge_w ? trial_w[DVS_W-1:0] : part_w[DVS_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge_w};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `HOS_ASSERT_IMP(a_start_idle, req_i.start, !busy_q, "Division started while busy")
  `HOS_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q), "Quotient flagged without a run")
  `HOS_ASSERT_IMP(a_busy_ends_done, $fell(busy_q), done_q, "Division ended without done")

endmodule

>>> sv/homography_object_steering.sv
// ----------------------------------------------------------------------------
// Homography object steering
// Turns one detected-object transaction into one drive command. A follow
// object projects its four template corners through the x and w rows of a
// Q16.16 homography, averages the projected columns and steers towards them
// with a proportional Q4.12 turn rate, a deadband of half min_turn_rate and
// saturation; a stop object sets a latch that holds the vehicle stopped until
// reset, and any other kind gives a zero command. Stop, no-action and latched
// transactions go from acceptance straight to the emit state, which loads the
// result register once the output register is free. A follow transaction makes
// five passes through the shared restoring divider (one per corner and one for
// the turn scaling) and five through the shared multiplier; a corner with a
// zero denominator skips its division. The input is stalled while a transaction
// is in progress, and the result register lets the next one be accepted while
// the previous result waits. Registers are written over APB at byte addresses
// 0, 4 and 8 and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
`include "homography_object_steering_defines.svh"

module homography_object_steering
  import hos_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hos_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hos_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_NUM    = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_DIFF   = 4'd6;
  localparam logic [3:0] S_TMUL   = 4'd7;
  localparam logic [3:0] S_TSTART = 4'd8;
  localparam logic [3:0] S_TDIV   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]                 state_q, state_d;
  hos_in_t                    in_q;
  logic                       stop_latch_q;
  logic [CENTER_W-1:0]        cfg_center_q;
  logic [RATE_W-1:0]          cfg_max_q;
  logic [RATE_W-1:0]          cfg_min_q;
  logic [1:0]                 mul_idx_q;
  logic [1:0]                 corner_q;
  logic signed [PRD_W-1:0]    prd_q [4];
  logic signed [NUM_W-1:0]    num_q;
  logic signed [NUM_W-1:0]    den_q;
  logic                       qneg_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [X_W-1:0]      x_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [TPROD_W-1:0]  tprod_q;
  logic                       res_speed_q;
  logic signed [TURN_W-1:0]   res_turn_q;
  logic                       out_valid_q;
  hos_out_t                   out_q;

  logic                       in_accept;
  logic                       is_follow;
  logic                       cfg_write;
  logic                       out_load;
  logic                       corner_skip;
  logic                       corner_done;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [NUM_W-1:0]    num_sum;
  logic signed [NUM_W-1:0]    den_sum;
  logic [NUM_W-1:0]           num_mag;
  logic [NUM_W-1:0]           den_mag;
  logic [TPROD_W-1:0]         tprod_mag;
  logic [ACC_W-1:0]           quo_ext;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic [QUO_W-1:0]           qm;
  logic signed [TURN_W-1:0]   turn_d;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  hos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_follow  = (in_data_i.object_kind == KIND_FOLLOW) && !stop_latch_q;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (paddr[3:2])
      REG_CENTER: prdata = APB_DW'(cfg_center_q);
      REG_MAX:    prdata = APB_DW'(cfg_max_q);
      REG_MIN:    prdata = APB_DW'(cfg_min_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_TMUL) begin
      mul_a = MUL_A_W'(diff_q);
      mul_b = {1'b0, cfg_max_q};
    end else begin
      case (mul_idx_q)
        2'd0: begin
          mul_a = MUL_A_W'(in_q.hom_r0c0);
          mul_b = {4'b0, in_q.obj_width};
        end
        2'd1: begin
          mul_a = MUL_A_W'(in_q.hom_r0c1);
          mul_b = {4'b0, in_q.obj_height};
        end
        2'd2: begin
          mul_a = MUL_A_W'(in_q.hom_r2c0);
          mul_b = {4'b0, in_q.obj_width};
        end
        default: begin
          mul_a = MUL_A_W'(in_q.hom_r2c1);
          mul_b = {4'b0, in_q.obj_height};
        end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    num_sum = NUM_W'(in_q.hom_r0c2)
            + (corner_q[0] ? NUM_W'(prd_q[0]) : NUM_W'(0))
            + (corner_q[1] ? NUM_W'(prd_q[1]) : NUM_W'(0));
    den_sum = NUM_W'(in_q.hom_r2c2)
            + (corner_q[0] ? NUM_W'(prd_q[2]) : NUM_W'(0))
            + (corner_q[1] ? NUM_W'(prd_q[3]) : NUM_W'(0));
    num_mag   = num_q[NUM_W-1] ? -num_q : num_q;
    den_mag   = den_q[NUM_W-1] ? -den_q : den_q;
    tprod_mag = tprod_q[TPROD_W-1] ? -tprod_q : tprod_q;
    quo_ext   = ACC_W'(div_rsp.quotient);
    acc_rnd   = acc_q + (acc_q[ACC_W-1] ? ACC_W'(RND_BIAS) : ACC_W'(0));
  end

  always_comb begin
    div_req.start = (state_q == S_TSTART) || ((state_q == S_DSTART) && (den_q != '0));
    if (state_q == S_TSTART) begin
      div_req.dividend = tprod_mag[QUO_W-1:0];
      div_req.divisor  = (cfg_center_q == '0) ? DVS_W'(1) : DVS_W'(cfg_center_q);
    end else begin
      div_req.dividend = {num_mag[DVS_W-1:0], {HOM_FRAC{1'b0}}};
      div_req.divisor  = den_mag[DVS_W-1:0];
    end
  end

  always_comb begin
    qm = div_rsp.quotient;
    if (qm <= QUO_W'(cfg_min_q[RATE_W-1:1])) begin
      turn_d = '0;
    end else if (qneg_q) begin
      turn_d = (qm > QUO_W'(SAT_NEG_MAG)) ? TURN_MIN : -qm[TURN_W-1:0];
    end else begin
      turn_d = (qm > QUO_W'(SAT_POS)) ? TURN_MAX : qm[TURN_W-1:0];
    end
  end

  assign corner_skip = (state_q == S_DSTART) && (den_q == '0);
  assign corner_done = corner_skip || ((state_q == S_DIV) && div_rsp.done);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = is_follow ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        if (mul_idx_q == 2'd3) begin
          state_d = S_NUM;
        end
      end
      S_NUM: state_d = S_DSTART;
      S_DSTART, S_DIV: begin
        if (corner_done) begin
          state_d = (corner_q == 2'd3) ? S_SHIFT : S_NUM;
        end else if (state_q == S_DSTART) begin
          state_d = S_DIV;
        end
      end
      S_SHIFT:  state_d = S_DIFF;
      S_DIFF:   state_d = S_TMUL;
      S_TMUL:   state_d = S_TSTART;
      S_TSTART: state_d = S_TDIV;
      S_TDIV: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      stop_latch_q <= 1'b0;
      cfg_center_q <= CENTER_RST;
      cfg_max_q    <= MAX_RST;
      cfg_min_q    <= MIN_RST;
      mul_idx_q    <= '0;
      corner_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && (in_data_i.object_kind == KIND_STOP)) begin
        stop_latch_q <= 1'b1;
      end
      if (cfg_write) begin
        case (paddr[3:2])
          REG_CENTER: cfg_center_q <= pwdata[CENTER_W-1:0];
          REG_MAX:    cfg_max_q    <= pwdata[RATE_W-1:0];
          REG_MIN:    cfg_min_q    <= pwdata[RATE_W-1:0];
          default:    cfg_center_q <= cfg_center_q;
        endcase
      end
      if (in_accept) begin
        mul_idx_q <= '0;
        corner_q  <= '0;
      end else begin
        if (state_q == S_MUL) begin
          mul_idx_q <= mul_idx_q + 1'b1;
        end
        if (corner_done) begin
          corner_q <= corner_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q        <= in_data_i;
      acc_q       <= '0;
      res_speed_q <= 1'b0;
      res_turn_q  <= '0;
    end
    case (state_q)
      S_MUL:    prd_q[mul_idx_q] <= mul_p[PRD_W-1:0];
      S_NUM: begin
        num_q <= num_sum;
        den_q <= den_sum;
      end
      S_DSTART: qneg_q <= num_q[NUM_W-1] ^ den_q[NUM_W-1];
      S_DIV: begin
        if (div_rsp.done) begin
          acc_q <= acc_q + (qneg_q ? -quo_ext : quo_ext);
        end
      end
      S_SHIFT:  x_q <= acc_rnd[ACC_W-1:FRAC_SH];
      S_DIFF:   diff_q <= DIFF_W'(x_q) - DIFF_W'(cfg_center_q);
      S_TMUL:   tprod_q <= mul_p[TPROD_W-1:0];
      S_TSTART: qneg_q <= !tprod_q[TPROD_W-1];
      S_TDIV: begin
        if (div_rsp.done) begin
          res_speed_q <= 1'b1;
          res_turn_q  <= turn_d;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.forward_speed <= res_speed_q;
      out_q.turn_rate     <= res_turn_q;
      out_q.stop_active   <= stop_latch_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HOS_ASSERT_NXT(a_latch_sticky, stop_latch_q, stop_latch_q,
                  "Stop latch cleared without reset")
  `HOS_ASSERT_IMP(a_done_in_wait, div_rsp.done, (state_q == S_DIV) || (state_q == S_TDIV),
                  "Quotient arrived outside a wait state")
  `HOS_ASSERT_IMP(a_stopped_zero, out_valid_o && out_data_o.stop_active,
                  !out_data_o.forward_speed && (out_data_o.turn_rate == '0),
                  "Stopped vehicle given a drive command")
  `HOS_ASSERT_IMP(a_turn_needs_speed, out_valid_o && (out_data_o.turn_rate != '0),
                  out_data_o.forward_speed, "Turn command without forward speed")

endmodule
